// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FPR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FPR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fpr_pkg.sv =====
// Package of constants and types for the FIFO page replacement block.
`default_nettype none

package fpr_pkg;

   localparam int unsigned FRAMES_DEFAULT    = 8;
   localparam int unsigned PAGE_BITS_DEFAULT = 16;
   localparam int unsigned SLOT_W_DEFAULT    = 3;
   localparam int unsigned CFG_W             = 4;
   localparam int unsigned FAULT_W           = 16;

   localparam logic [CFG_W-1:0]   FRAMES_IN_USE_RESET = 4'd8;
   localparam logic [FAULT_W-1:0] FAULT_MAX           = 16'hFFFF;

   typedef enum logic [1:0] {
      FPR_IDLE,
      FPR_SCAN,
      FPR_DONE
   } fpr_state_type;

endpackage

`default_nettype wire

// ===== rtl/fpr_if.sv =====
// Channel interfaces: page reference, result and configuration write.
`default_nettype none

interface fpr_req_if #(
   parameter int unsigned PAGE_BITS = fpr_pkg::PAGE_BITS_DEFAULT
);
   logic                 valid;
   logic                 ready;
   logic [PAGE_BITS-1:0] page_number;

   modport source (output valid, output page_number, input ready);
   modport sink   (input valid, input page_number, output ready);
endinterface

interface fpr_rsp_if #(
   parameter int unsigned PAGE_BITS = fpr_pkg::PAGE_BITS_DEFAULT,
   parameter int unsigned SLOT_W    = fpr_pkg::SLOT_W_DEFAULT
);
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [SLOT_W-1:0]           frame_slot;
   logic                        evicted_valid;
   logic [PAGE_BITS-1:0]        evicted_page;
   logic [fpr_pkg::FAULT_W-1:0] fault_total;

   modport source (output valid, output hit, output frame_slot, output evicted_valid,
                   output evicted_page, output fault_total, input ready);
   modport sink   (input valid, input hit, input frame_slot, input evicted_valid,
                   input evicted_page, input fault_total, output ready);
endinterface

interface fpr_csr_if;
   logic                      valid;
   logic                      ready;
   logic [fpr_pkg::CFG_W-1:0] frames_in_use;

   modport source (output valid, output frames_in_use, input ready);
   modport sink   (input valid, input frames_in_use, output ready);
endinterface

`default_nettype wire

// ===== rtl/fifo_page_replacement.sv =====
// FIFO page replacement unit: top level with frame memory and scan sequencer.
`default_nettype none

// Each req beat carries one page reference. The frame table sits in a
// single-port synchronous memory (one read or one write per cycle, read data
// registered) with valid bits in flops, so reset empties every frame at
// once and no clearing pass is needed. A reference scans frames 0 .. n-1
// in order, one memory read per cycle, with n the frames_in_use register
// clamped to 1 .. FRAMES. A hit or the end of the scan moves to the done
// state, which loads the result register and, on a miss, writes the new
// page into the frame at the FIFO pointer in the same cycle. The sequencer
// then returns to idle, where the next req beat is taken; no new reference
// is taken before the block is through with the current one. The result
// register decouples the rsp side: the next req beat is taken while a result
// still waits, and that item holds in its final cycle until the result
// register is free. The req and csr channels are not ready during reset;
// outside reset the csr channel is always ready; write it only while the
// block is idle. Frame contents, valid bits, pointer and fault count survive
// a csr write.
module fifo_page_replacement #(
   parameter int unsigned FRAMES    = fpr_pkg::FRAMES_DEFAULT,
   parameter int unsigned PAGE_BITS = fpr_pkg::PAGE_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   fpr_req_if.sink   req_bus,
   fpr_rsp_if.source rsp_bus,
   fpr_csr_if.sink   csr_bus
);

   localparam int unsigned SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int unsigned CNT_W  = $clog2(FRAMES + 1);
   localparam int unsigned NW     = (CNT_W > fpr_pkg::CFG_W) ? CNT_W : fpr_pkg::CFG_W;
   localparam logic [NW-1:0]    FRAMES_NW  = NW'(FRAMES);
   localparam logic [CNT_W-1:0] FRAMES_CNT = CNT_W'(FRAMES);

   // Sequencer state.
   fpr_pkg::fpr_state_type state_ff, state_in;

   // Configuration and persistent replacement state.
   logic [fpr_pkg::CFG_W-1:0]   frames_in_use_ff;
   logic [FRAMES-1:0]           valid_ff;
   logic [SLOT_W-1:0]           ptr_ff;
   logic [fpr_pkg::FAULT_W-1:0] fault_ff;

   // Frame page memory.
   logic [PAGE_BITS-1:0] frame_mem [FRAMES];
   logic [PAGE_BITS-1:0] rd_data_ff;

   // Per-item working registers.
   logic [PAGE_BITS-1:0] page_ff;
   logic [CNT_W-1:0]     n_ff;
   logic [CNT_W-1:0]     issue_ff;     // next frame to read
   logic [SLOT_W-1:0]    cmp_idx_ff;   // frame whose data is in rd_data_ff
   logic                 cmp_live_ff;  // rd_data_ff holds a fresh read
   logic                 hit_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic                 ev_valid_ff;
   logic [PAGE_BITS-1:0] ev_page_ff;

   // Result register.
   logic                        rsp_valid_ff;
   logic                        rsp_hit_ff;
   logic [SLOT_W-1:0]           rsp_slot_ff;
   logic                        rsp_ev_valid_ff;
   logic [PAGE_BITS-1:0]        rsp_ev_page_ff;
   logic [fpr_pkg::FAULT_W-1:0] rsp_fault_ff;

   // Control decode.
   logic                        req_fire;
   logic                        hit_now;
   logic                        issue_more;
   logic                        rd_en;
   logic                        commit;
   logic                        wr_en;
   logic [NW-1:0]               fiu_ext;
   logic [CNT_W-1:0]            n_eff;
   logic [SLOT_W-1:0]           ptr_eff;
   logic [CNT_W-1:0]            ptr_plus;
   logic [SLOT_W-1:0]           ptr_next;
   logic [fpr_pkg::FAULT_W-1:0] fault_inc;

   // Frame count in use: zero acts as one, above FRAMES acts as FRAMES.
   always_comb begin
      fiu_ext = NW'(frames_in_use_ff);
      if (fiu_ext == '0) begin
         n_eff = CNT_W'(1);
      end else if (fiu_ext > FRAMES_NW) begin
         n_eff = FRAMES_CNT;
      end else begin
         n_eff = fiu_ext[CNT_W-1:0];
      end
   end

   // Pointer left beyond a lowered frame count restarts at frame 0.
   always_comb begin
      ptr_eff  = (CNT_W'(ptr_ff) < n_ff) ? ptr_ff : '0;
      ptr_plus = CNT_W'(ptr_eff) + CNT_W'(1);
      ptr_next = (ptr_plus >= n_ff) ? '0 : ptr_plus[SLOT_W-1:0];
   end

   assign fault_inc = (fault_ff == fpr_pkg::FAULT_MAX) ? fault_ff : fault_ff + 1'b1;

   assign req_fire   = req_bus.valid && req_bus.ready;
   assign hit_now    = cmp_live_ff && valid_ff[cmp_idx_ff] && (rd_data_ff == page_ff);
   assign issue_more = (issue_ff < n_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fpr_pkg::FPR_IDLE: begin
            if (req_fire) state_in = fpr_pkg::FPR_SCAN;
         end
         fpr_pkg::FPR_SCAN: begin
            if (hit_now || !issue_more) state_in = fpr_pkg::FPR_DONE;
         end
         fpr_pkg::FPR_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) state_in = fpr_pkg::FPR_IDLE;
         end
         default: state_in = fpr_pkg::FPR_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_bus.ready = 1'b0;
      rd_en         = 1'b0;
      commit        = 1'b0;
      unique case (state_ff)
         fpr_pkg::FPR_IDLE: req_bus.ready = !reset;
         fpr_pkg::FPR_SCAN: rd_en = !hit_now && issue_more;
         fpr_pkg::FPR_DONE: commit = !rsp_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   assign wr_en = commit && !hit_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= fpr_pkg::FPR_IDLE;
      else       state_ff <= state_in;
   end

   // csr write port.
   assign csr_bus.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= fpr_pkg::FRAMES_IN_USE_RESET;
      end else if (csr_bus.valid) begin
         frames_in_use_ff <= csr_bus.frames_in_use;
      end
   end

   // Frame memory: one access per cycle, registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[ptr_eff] <= page_ff;
      end else if (rd_en) begin
         rd_data_ff <= frame_mem[issue_ff[SLOT_W-1:0]];
      end
   end

   // Replacement state, committed on a miss.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
         fault_ff <= '0;
      end else if (wr_en) begin
         valid_ff[ptr_eff] <= 1'b1;
         ptr_ff            <= ptr_next;
         fault_ff          <= fault_inc;
      end
   end

   // Scan pipeline: issue one read per cycle, compare the one before.
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_live_ff <= 1'b0;
      end else if (req_fire) begin
         cmp_live_ff <= 1'b0;
      end else if (state_ff == fpr_pkg::FPR_SCAN) begin
         cmp_live_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         page_ff     <= req_bus.page_number;
         n_ff        <= n_eff;
         issue_ff    <= '0;
         ev_valid_ff <= 1'b0;
         ev_page_ff  <= '0;
      end else if (state_ff == fpr_pkg::FPR_SCAN) begin
         if (rd_en) begin
            issue_ff   <= issue_ff + 1'b1;
            cmp_idx_ff <= issue_ff[SLOT_W-1:0];
         end
         // The victim frame passes by during the full scan of a miss.
         if (cmp_live_ff && (cmp_idx_ff == ptr_eff)) begin
            ev_valid_ff <= valid_ff[cmp_idx_ff];
            ev_page_ff  <= rd_data_ff;
         end
         if (hit_now) begin
            hit_ff  <= 1'b1;
            slot_ff <= cmp_idx_ff;
         end else if (!issue_more) begin
            hit_ff  <= 1'b0;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_hit_ff      <= hit_ff;
         rsp_slot_ff     <= hit_ff ? slot_ff : ptr_eff;
         rsp_ev_valid_ff <= !hit_ff && ev_valid_ff;
         rsp_ev_page_ff  <= (!hit_ff && ev_valid_ff) ? ev_page_ff : '0;
         rsp_fault_ff    <= hit_ff ? fault_ff : fault_inc;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.hit           = rsp_hit_ff;
   assign rsp_bus.frame_slot    = rsp_slot_ff;
   assign rsp_bus.evicted_valid = rsp_ev_valid_ff;
   assign rsp_bus.evicted_page  = rsp_ev_page_ff;
   assign rsp_bus.fault_total   = rsp_fault_ff;

endmodule

`default_nettype wire

// ===== rtl/fpr_checker.sv =====
// Port-level checker for the FIFO page replacement block, with its bind.
`default_nettype none

`include "assert_macros.svh"

module fpr_checker #(
   parameter int unsigned PAGE_BITS = fpr_pkg::PAGE_BITS_DEFAULT
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_hit,
   input logic                        rsp_evicted_valid,
   input logic [PAGE_BITS-1:0]        rsp_evicted_page,
   input logic [fpr_pkg::FAULT_W-1:0] rsp_fault_total
);

   logic [1:0]                  pend_ff;
   logic                        seen_ff;
   logic [fpr_pkg::FAULT_W-1:0] last_fault_ff;
   logic                        req_fire;
   logic                        rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         seen_ff <= 1'b0;
      end else begin
         pend_ff <= pend_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
         if (rsp_fire) seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) last_fault_ff <= rsp_fault_total;
   end

   `FPR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fault_total) && $stable(rsp_hit), "rsp beat dropped or changed while stalled")
   `FPR_ASSERT_IMP(a_rsp_has_req, clock, reset, rsp_valid, pend_ff != 2'd0, "rsp beat without a pending req")
   `FPR_ASSERT_IMP(a_hit_no_evict, clock, reset, rsp_valid && rsp_hit, !rsp_evicted_valid && (rsp_evicted_page == '0), "hit reports an eviction")
   `FPR_ASSERT_IMP(a_hit_count, clock, reset, rsp_valid && seen_ff && rsp_hit, rsp_fault_total == last_fault_ff, "fault count moved on a hit")
   `FPR_ASSERT_IMP(a_miss_count, clock, reset, rsp_valid && seen_ff && !rsp_hit && (last_fault_ff != fpr_pkg::FAULT_MAX), rsp_fault_total == (last_fault_ff + 1'b1), "fault count not bumped on a miss")

endmodule

bind fifo_page_replacement fpr_checker #(
   .PAGE_BITS (PAGE_BITS)
) u_fpr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_hit           (rsp_bus.hit),
   .rsp_evicted_valid (rsp_bus.evicted_valid),
   .rsp_evicted_page  (rsp_bus.evicted_page),
   .rsp_fault_total   (rsp_bus.fault_total)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the FIFO page replacement block.
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned FRAMES  = fpr_pkg::FRAMES_DEFAULT;
   localparam int unsigned PAGE_W  = fpr_pkg::PAGE_BITS_DEFAULT;
   localparam int unsigned SLOT_W  = fpr_pkg::SLOT_W_DEFAULT;
   localparam int unsigned CFG_W   = fpr_pkg::CFG_W;
   localparam int unsigned FAULT_W = fpr_pkg::FAULT_W;

   // receiver hold-off used once to back the block up into its input
   localparam int LONG_HOLD  = 400;
   localparam int SEGMENTS   = 8;
   localparam int SEG_ITEMS  = 140;
   localparam int TAIL_ITEMS = 6;
   localparam int TAIL_WAIT  = 24;

   // one result beat, same field order as the rsp channel
   typedef struct packed {
      logic                hit;
      logic [SLOT_W-1:0]   frame_slot;
      logic                evicted_valid;
      logic [PAGE_W-1:0]   evicted_page;
      logic [FAULT_W-1:0]  fault_total;
   } lookup_result_type;

   typedef enum logic {
      ROW_REF,
      ROW_CFG
   } row_kind_type;

   // directed row: a page reference or a frames_in_use write; "typed" rows
   // carry their own expected result, the rest go through the predictor
   typedef struct packed {
      row_kind_type      kind;
      logic              typed;
      logic [PAGE_W-1:0] value;
      lookup_result_type want;
   } stim_row_type;

   localparam int DIRECTED_LEN = 27;

   localparam stim_row_type DIRECTED_ROWS [DIRECTED_LEN] = '{
      // out of reset: all frames empty, frames_in_use = 8
      '{ROW_REF, 1'b1, 16'h0000, '{1'b0, 3'd0, 1'b0, 16'h0000, 16'd1}},
      '{ROW_REF, 1'b1, 16'hFFFF, '{1'b0, 3'd1, 1'b0, 16'h0000, 16'd2}},
      '{ROW_REF, 1'b1, 16'h0000, '{1'b1, 3'd0, 1'b0, 16'h0000, 16'd2}},
      '{ROW_REF, 1'b1, 16'hFFFF, '{1'b1, 3'd1, 1'b0, 16'h0000, 16'd2}},
      // fill frames 2..7
      '{ROW_REF, 1'b0, 16'hA5A5, '0},
      '{ROW_REF, 1'b0, 16'h5A5A, '0},
      '{ROW_REF, 1'b0, 16'h8000, '0},
      '{ROW_REF, 1'b0, 16'h0001, '0},
      '{ROW_REF, 1'b0, 16'h1234, '0},
      '{ROW_REF, 1'b0, 16'hFEDC, '0},
      // pointer wrapped: first eviction throws out page 0 from frame 0
      '{ROW_REF, 1'b1, 16'h4321, '{1'b0, 3'd0, 1'b1, 16'h0000, 16'd9}},
      '{ROW_REF, 1'b0, 16'hFFFF, '0},
      '{ROW_REF, 1'b1, 16'h7777, '{1'b0, 3'd1, 1'b1, 16'hFFFF, 16'd10}},
      '{ROW_REF, 1'b0, 16'h0F0F, '0},
      '{ROW_REF, 1'b0, 16'hF0F0, '0},
      '{ROW_REF, 1'b0, 16'h3C3C, '0},
      // shrink to 3 with pointer at 5: replacement falls back to frame 0,
      // and 0x1234 now sits in frames 0 and 6
      '{ROW_CFG, 1'b0, 16'h0003, '0},
      '{ROW_REF, 1'b0, 16'h1234, '0},
      // above range acts as 8: duplicate page, lowest frame wins
      '{ROW_CFG, 1'b0, 16'h000F, '0},
      '{ROW_REF, 1'b0, 16'h1234, '0},
      '{ROW_REF, 1'b0, 16'hFEDC, '0},
      // zero acts as one frame
      '{ROW_CFG, 1'b0, 16'h0000, '0},
      '{ROW_REF, 1'b0, 16'h2222, '0},
      '{ROW_REF, 1'b0, 16'h3333, '0},
      '{ROW_REF, 1'b0, 16'h3333, '0},
      // grow back: contents beyond the small window survived
      '{ROW_CFG, 1'b0, 16'h0008, '0},
      '{ROW_REF, 1'b0, 16'h1234, '0}
   };

   // frames_in_use per random segment; extremes and every bit both ways
   localparam logic [CFG_W-1:0] SEG_FRAMES [SEGMENTS] =
      '{4'd1, 4'd8, 4'd0, 4'd15, 4'd5, 4'd2, 4'd10, 4'd3};

   // idling modes: none, sender idle, receiver stall, both
   localparam int SEND_IDLE [4] = '{0, 55, 0, 30};
   localparam int RSP_STALL [4] = '{0, 0, 55, 30};

   logic clock = 1'b0;
   logic reset = 1'b1;

   fpr_req_if req_ch ();
   fpr_rsp_if rsp_ch ();
   fpr_csr_if csr_ch ();

   fifo_page_replacement dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state: frame table, FIFO pointer, fault tally, register
   logic [PAGE_W-1:0]  res_page [FRAMES];
   logic               res_valid [FRAMES];
   int unsigned        fifo_ptr;
   logic [FAULT_W-1:0] fault_tally;
   logic [CFG_W-1:0]   frames_cfg;

   lookup_result_type pending_results [$];
   int mismatches = 0;

   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;

   // long hold-off handshake between main flow and receiver
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
   endtask

   // Walks the frames in use for the page; on a miss, replaces at the FIFO
   // pointer (frame 0 if the pointer sits past a lowered count).
   function automatic lookup_result_type resolve_reference(input logic [PAGE_W-1:0] pg);
      lookup_result_type r;
      int unsigned n;
      int unsigned p;
      int unsigned i;
      bit found;
      r = '0;
      found = 1'b0;
      n = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES) ? FRAMES : frames_cfg;
      for (i = 0; i < n; i++) begin
         if (!found && res_valid[i] && res_page[i] == pg) begin
            found = 1'b1;
            r.frame_slot = i[SLOT_W-1:0];
         end
      end
      if (found) begin
         r.hit = 1'b1;
      end else begin
         p = (fifo_ptr >= n) ? 0 : fifo_ptr;
         if (fault_tally != fpr_pkg::FAULT_MAX) fault_tally++;
         if (res_valid[p]) begin
            r.evicted_valid = 1'b1;
            r.evicted_page  = res_page[p];
         end
         res_page[p]  = pg;
         res_valid[p] = 1'b1;
         r.frame_slot = p[SLOT_W-1:0];
         p++;
         fifo_ptr = (p >= n) ? 0 : p;
      end
      r.fault_total = fault_tally;
      return r;
   endfunction

   // Offers one page; holds valid across back-to-back beats so it is never
   // dropped and re-raised within one step.
   task automatic send_page(input logic [PAGE_W-1:0] pg, input bit use_given,
                            input lookup_result_type given);
      lookup_result_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.page_number <= pg;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = resolve_reference(pg);
      pending_results.push_back(use_given ? given : predicted);
   endtask

   task automatic drain_block;
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // frames_in_use is only written with the block idle
   task automatic write_frames(input logic [CFG_W-1:0] v);
      drain_block();
      csr_ch.valid         <= 1'b1;
      csr_ch.frames_in_use <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      frames_cfg = v;
   endtask

   task automatic set_idling(input int mode);
      sender_idle_pct = SEND_IDLE[mode];
      rsp_stall_pct   = RSP_STALL[mode];
   endtask

   task automatic check_beat;
      lookup_result_type w;
      if (pending_results.size() == 0) begin
         report_mismatch("unexpected result beat", 32'(rsp_ch.fault_total), 32'd0);
      end else begin
         w = pending_results.pop_front();
         if (rsp_ch.hit !== w.hit)
            report_mismatch("hit", 32'(rsp_ch.hit), 32'(w.hit));
         if (rsp_ch.frame_slot !== w.frame_slot)
            report_mismatch("frame_slot", 32'(rsp_ch.frame_slot), 32'(w.frame_slot));
         if (rsp_ch.evicted_valid !== w.evicted_valid)
            report_mismatch("evicted_valid", 32'(rsp_ch.evicted_valid),
                            32'(w.evicted_valid));
         if (rsp_ch.evicted_page !== w.evicted_page)
            report_mismatch("evicted_page", 32'(rsp_ch.evicted_page),
                            32'(w.evicted_page));
         if (rsp_ch.fault_total !== w.fault_total)
            report_mismatch("fault_total", 32'(rsp_ch.fault_total),
                            32'(w.fault_total));
      end
   endtask

   // Receiver: checks each accepted beat, then picks next ready. Values read
   // here at the edge are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) check_beat();
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      int row;
      int seg;
      int k;
      int pool_len;
      logic [PAGE_W-1:0] pool [12];
      logic [PAGE_W-1:0] pg;
      logic [PAGE_W-1:0] sweep_page;

      req_ch.valid         = 1'b0;
      req_ch.page_number   = '0;
      csr_ch.valid         = 1'b0;
      csr_ch.frames_in_use = '0;

      for (k = 0; k < FRAMES; k++) begin
         res_page[k]  = '0;
         res_valid[k] = 1'b0;
      end
      fifo_ptr    = 0;
      fault_tally = '0;
      frames_cfg  = fpr_pkg::FRAMES_IN_USE_RESET;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      set_idling(3);
      for (row = 0; row < DIRECTED_LEN; row++) begin
         if (DIRECTED_ROWS[row].kind == ROW_CFG)
            write_frames(DIRECTED_ROWS[row].value[CFG_W-1:0]);
         else
            send_page(DIRECTED_ROWS[row].value, DIRECTED_ROWS[row].typed,
                      DIRECTED_ROWS[row].want);
      end

      // Random segments: a small working set drives most references so hits
      // and evictions both happen; the rest are arbitrary pages.
      for (seg = 0; seg < SEGMENTS; seg++) begin
         write_frames(SEG_FRAMES[seg]);
         set_idling(seg % 4);
         pool_len = $urandom_range(12, 2);
         for (k = 0; k < 12; k++) pool[k] = PAGE_W'($urandom_range(16'hFFFF, 0));
         pool[0] = (seg % 2) ? 16'hFFFF : 16'h0000;
         // block fills up behind a stalled receiver while refs keep coming
         if (seg == 4) hold_requests++;
         for (k = 0; k < SEG_ITEMS; k++) begin
            if ($urandom_range(99) < 72)
               pg = pool[$urandom_range(pool_len - 1, 0)];
            else
               pg = PAGE_W'($urandom_range(16'hFFFF, 0));
            send_page(pg, 1'b0, '0);
         end
      end

      // One frame, a fresh page every beat with no idling: each reference
      // faults and evicts the page before it.
      write_frames(4'd1);
      set_idling(0);
      sweep_page = 16'h0100;
      for (k = 0; k < TAIL_ITEMS; k++) begin
         send_page(sweep_page, 1'b0, '0);
         sweep_page++;
      end

      drain_block();
      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatches == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
